[rtl/core/relock_sweep_sequencer_top_macros.svh]
// Assertion macros for the relock sweep sequencer checker.
// No dependencies; include by bare file name.
`ifndef RELOCK_SWEEP_SEQUENCER_TOP_MACROS_SVH
`define RELOCK_SWEEP_SEQUENCER_TOP_MACROS_SVH

// cond must never be true outside reset
`define RSS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rss check failed");

// a implies b on the next edge
`define RSS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rss check failed");

`endif

[rtl/core/rss_pkg.sv]
// Shared types and constants for the relock sweep sequencer.
// No dependencies.
package rss_pkg;

    localparam int FINE_STEPS = 256;
    localparam int FPOS_W = ($clog2(FINE_STEPS) + 1 > 9) ? $clog2(FINE_STEPS) + 1 : 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FCNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_RAIL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_RAIL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_END  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_END    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT  = 3'd7;

    typedef struct packed {
        logic [15:0]       upper_rail;
        logic [15:0]       lower_rail;
        logic [7:0]        coarse_start;
        logic [7:0]        coarse_end;
        logic [7:0]        fine_start;
        logic [8:0]        fine_end;
        logic [11:0]       detect_threshold;
        logic [FCNT_W-1:0] fail_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] coarse_value;
        logic [7:0] fine_value;
        logic       searching;
        logic       lock_lamp;
        logic       fail_lamp;
    } res_t;

endpackage

[rtl/core/rss_sample_if.sv]
// Input sample channel: valid/ready with filter and error readings.
// Depends on nothing.
interface rss_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] filter_sample;
    logic [11:0] error_sample;

    modport source (output valid, output filter_sample, output error_sample, input ready);
    modport sink (input valid, input filter_sample, input error_sample, output ready);
endinterface

[rtl/core/rss_result_if.sv]
// Result channel: valid/ready with DAC drive values and lamps.
// Depends on nothing.
interface rss_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] coarse_value;
    logic [7:0] fine_value;
    logic       searching;
    logic       lock_lamp;
    logic       fail_lamp;

    modport source (output valid, output coarse_value, output fine_value,
                    output searching, output lock_lamp, output fail_lamp, input ready);
    modport sink (input valid, input coarse_value, input fine_value,
                  input searching, input lock_lamp, input fail_lamp, output ready);
endinterface

[rtl/core/rss_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on nothing.
interface rss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/rss_cfg_regs.sv]
// Configuration register file for the relock sweep sequencer.
// Depends on rss_pkg and rss_cfg_if.
module rss_cfg_regs
    import rss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rss_cfg_if.sink   cfg,
    output cfg_t      cfg_regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_UPPER_RAIL:   cfg_next.upper_rail       = cfg.data;
                REG_LOWER_RAIL:   cfg_next.lower_rail       = cfg.data;
                REG_COARSE_START: cfg_next.coarse_start     = cfg.data[7:0];
                REG_COARSE_END:   cfg_next.coarse_end       = cfg.data[7:0];
                REG_FINE_START:   cfg_next.fine_start       = cfg.data[7:0];
                REG_FINE_END:     cfg_next.fine_end         = cfg.data[8:0];
                REG_DETECT_THR:   cfg_next.detect_threshold = cfg.data[11:0];
                REG_FAIL_LIMIT:   cfg_next.fail_limit       = cfg.data[FCNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_rail       <= 16'hFFFF;
            cfg_reg.lower_rail       <= 16'd0;
            cfg_reg.coarse_start     <= 8'd0;
            cfg_reg.coarse_end       <= 8'd255;
            cfg_reg.fine_start       <= 8'd0;
            cfg_reg.fine_end         <= 9'd256;
            cfg_reg.detect_threshold <= 12'd2000;
            cfg_reg.fail_limit       <= FCNT_W'(20);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/rss_sweep_core.sv]
// Sweep state and per-tick step logic: watch/search control, DAC position
// stepping, failure counting and lamps. Depends on rss_pkg.
module rss_sweep_core
    import rss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        step_en,
    input  logic [15:0] filter_sample,
    input  logic [11:0] error_sample,
    output res_t        res
);

    logic              search_reg,  search_next;
    logic [7:0]        cpos_reg,    cpos_next;
    logic [FPOS_W-1:0] fpos_reg,    fpos_next;
    logic              crossed_reg, crossed_next;
    logic [FCNT_W-1:0] fcnt_reg,    fcnt_next;
    logic              fail_reg,    fail_next;
    logic              lock_reg,    lock_next;

    logic              entering;
    logic              last_coarse;
    logic [FPOS_W-1:0] fine_inc;
    logic [FPOS_W-1:0] fine_limit;
    logic [FPOS_W-1:0] fine_end_ext;
    logic [FCNT_W:0]   fcnt_inc;

    always_comb
    begin
        entering     = !search_reg && ((filter_sample > cfg.upper_rail)
                                    || (filter_sample < cfg.lower_rail));
        search_next  = search_reg;
        cpos_next    = cpos_reg;
        fpos_next    = fpos_reg;
        crossed_next = crossed_reg;
        fcnt_next    = fcnt_reg;
        fail_next    = fail_reg;
        lock_next    = lock_reg;
        if (entering)
        begin
            search_next  = 1'b1;
            crossed_next = 1'b0;
            fcnt_next    = '0;
            fail_next    = 1'b0;
            lock_next    = 1'b0;
            cpos_next    = cfg.coarse_start;
            fpos_next    = FPOS_W'(cfg.fine_start);
        end

        res.coarse_value = 8'd0;
        res.fine_value   = 8'd0;

        last_coarse  = cpos_next >= cfg.coarse_end;
        fine_inc     = fpos_next + FPOS_W'(1);
        fine_end_ext = FPOS_W'(cfg.fine_end);
        fine_limit   = (last_coarse && (fine_end_ext < FPOS_W'(FINE_STEPS)))
                     ? fine_end_ext : FPOS_W'(FINE_STEPS);
        fcnt_inc     = {1'b0, fcnt_next} + (FCNT_W+1)'(1);

        if (search_next)
        begin
            res.coarse_value = cpos_next;
            res.fine_value   = fpos_next[7:0];
            if (error_sample < cfg.detect_threshold)
            begin
                crossed_next = 1'b1;
            end
            if ((error_sample > cfg.detect_threshold) && crossed_next)
            begin
                search_next  = 1'b0;
                crossed_next = 1'b0;
                fail_next    = 1'b0;
                lock_next    = 1'b1;
            end
            else if (fine_inc < fine_limit)
            begin
                fpos_next = fine_inc;
            end
            else if (!last_coarse)
            begin
                cpos_next = cpos_next + 8'd1;
                fpos_next = '0;
            end
            else
            begin
                cpos_next = cfg.coarse_start;
                fpos_next = FPOS_W'(cfg.fine_start);
                if (fcnt_inc >= {1'b0, cfg.fail_limit})
                begin
                    fcnt_next = cfg.fail_limit;
                    fail_next = 1'b1;
                end
                else
                begin
                    fcnt_next = fcnt_inc[FCNT_W-1:0];
                end
            end
        end

        res.searching = search_next;
        res.lock_lamp = lock_next;
        res.fail_lamp = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reg  <= 1'b0;
            cpos_reg    <= '0;
            fpos_reg    <= '0;
            crossed_reg <= 1'b0;
            fcnt_reg    <= '0;
            fail_reg    <= 1'b0;
            lock_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            search_reg  <= search_next;
            cpos_reg    <= cpos_next;
            fpos_reg    <= fpos_next;
            crossed_reg <= crossed_next;
            fcnt_reg    <= fcnt_next;
            fail_reg    <= fail_next;
            lock_reg    <= lock_next;
        end
    end

endmodule

[rtl/core/relock_sweep_sequencer_top.sv]
// A sample transfer is registered in the input register; its step result is registered in the result register.
// Throughput: one sample per cycle while the result is taken; input register, step logic, result register.
// The input stage stalls only while both registers are full and the result is not taken.
// Reset (rst_n low, async): watch mode, lamps off, registers at defaults.
// Depends on rss_pkg, the rss_*_if interfaces, rss_cfg_regs and rss_sweep_core.
module relock_sweep_sequencer_top
    import rss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rss_sample_if.sink    sample,
    rss_result_if.source  result,
    rss_cfg_if.sink       cfg
);

    cfg_t        cfg_regs;
    res_t        step_res;
    logic        advance;
    logic        step_en;

    logic        s1_valid_reg;
    logic [15:0] s1_filter_reg;
    logic [11:0] s1_error_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;

    assign advance      = !out_valid_reg || result.ready;
    assign step_en      = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;

    rss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    rss_sweep_core u_sweep_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_regs),
        .step_en       (step_en),
        .filter_sample (s1_filter_reg),
        .error_sample  (s1_error_reg),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_filter_reg <= sample.filter_sample;
            s1_error_reg  <= sample.error_sample;
        end
        if (step_en)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.coarse_value = out_res_reg.coarse_value;
    assign result.fine_value   = out_res_reg.fine_value;
    assign result.searching    = out_res_reg.searching;
    assign result.lock_lamp    = out_res_reg.lock_lamp;
    assign result.fail_lamp    = out_res_reg.fail_lamp;

endmodule

[rtl/core/rss_checker.sv]
// Port-level checks for relock_sweep_sequencer_top, bound to the top level.
// Depends on relock_sweep_sequencer_top_macros.svh.
`include "relock_sweep_sequencer_top_macros.svh"

module rss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] coarse_value,
    input logic [7:0] fine_value,
    input logic       searching,
    input logic       lock_lamp,
    input logic       fail_lamp
);

    // fail lamp only lights during a search
    `RSS_ASSERT_NEVER(a_fail_needs_search, clk, rst_n, out_valid && fail_lamp && !searching)
    // lock lamp is cleared on search entry
    `RSS_ASSERT_NEVER(a_lock_not_searching, clk, rst_n, out_valid && lock_lamp && searching)
    // a watch tick with no lock ever seen drives zeros
    `RSS_ASSERT_NEVER(a_idle_drive_zero, clk, rst_n,
        out_valid && !searching && !lock_lamp && ((coarse_value != 8'd0) || (fine_value != 8'd0)))
    // stalled result holds
    `RSS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable({coarse_value, fine_value, searching, lock_lamp, fail_lamp}))

endmodule

bind relock_sweep_sequencer_top rss_checker u_rss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .coarse_value (result.coarse_value),
    .fine_value   (result.fine_value),
    .searching    (result.searching),
    .lock_lamp    (result.lock_lamp),
    .fail_lamp    (result.fail_lamp)
);
